@@ sv/bdlsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlsp_pkg
// types, constants and elaboration-time table helpers for the drive loss block
// ----------------------------------------------------------------------------
package bdlsp_pkg;

  // drive kind codes as they arrive on the input channel
  localparam logic [2:0] FUNC_VBELT   = 3'd0;
  localparam logic [2:0] FUNC_NOTCH   = 3'd1;
  localparam logic [2:0] FUNC_SYNC    = 3'd2;
  localparam logic [2:0] FUNC_DIRECT  = 3'd3;
  localparam logic [2:0] FUNC_SPEC    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [23:0] POWER_MAX = 24'hFFFFFF;
  localparam logic [16:0] EFF_ONE   = 17'd65536;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  // exponent rates in q0.32
  localparam logic [31:0] K1_Q32 = 32'd88819795;
  localparam logic [31:0] K2_Q32 = 32'd970769983;
  // loss coefficients over 100 in q0.30
  localparam logic [22:0] C1_Q30 = 23'd8041869;
  localparam logic [25:0] C2_Q30 = 26'd44413913;
  localparam logic [26:0] C3_Q30 = 27'd44696726;
  // ceil(2^33/7), exact floor(x/7) for x below 2^30
  localparam logic [30:0] RECIP7 = 31'd1227133514;

  localparam int QDEPTH     = 2;
  localparam int DIV_STAGES = 24;

  typedef enum logic [2:0] {
    KIND_VBELT,
    KIND_NOTCH,
    KIND_SYNC,
    KIND_DIRECT,
    KIND_SPEC
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] p;
    logic [16:0] e;
  } item_t;

  typedef struct packed {
    logic [31:0] nh;
    logic [23:0] nl;
    logic [30:0] den;
  } div_in_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] motor;
    logic        sat;
    logic        zero;
    logic [16:0] e;
  } side_t;

  // shift and subtract quotient, only evaluated while building the table
  function automatic longint unsigned div_small(longint unsigned num, int unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= 64'(den)) begin
        r    = r - 64'(den);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor q2.30 of exp(-step) by the series summed up to its term of power 24
  function automatic longint unsigned exp_base(longint unsigned step);
    longint unsigned term;
    longint          sum;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int n = 1; n <= 24; n++) begin
      term = div_small((term * step) >> 30, n);
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum > 0) ? longint'(sum) : 64'd0;
  endfunction

  // table entry i as repeated rounded products of the base
  function automatic logic [30:0] exp_entry(int unsigned i, longint unsigned base);
    longint unsigned t;
    t = 64'd1 << 30;
    for (int unsigned k = 1; k <= i; k++) begin
      t = (t * base + (64'd1 << 29)) >> 30;
    end
    return t[30:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/bdlsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlsp_front
// input register, drive kind decode and capture of the specified efficiency
// ----------------------------------------------------------------------------
module bdlsp_front import bdlsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [23:0] in_power,
  input  wire logic [16:0] spec_eff,
  output logic             push,
  input  wire logic        q_full,
  output item_t            item
);

  logic  fv_r, fv_nxt;
  item_t item_r;
  kind_t kind;

  always_comb begin
    case (in_func)
      FUNC_NOTCH:  kind = KIND_NOTCH;
      FUNC_SYNC:   kind = KIND_SYNC;
      FUNC_DIRECT: kind = KIND_DIRECT;
      FUNC_SPEC:   kind = KIND_SPEC;
      default:     kind = KIND_VBELT;  // codes above specified act as v-belt
    endcase
  end

  assign in_ready = !fv_r || !q_full;
  assign push     = fv_r && !q_full;
  assign item     = item_r;

  always_comb begin
    fv_nxt = fv_r;
    if (in_valid && in_ready) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    if (in_valid && in_ready) begin
      item_r.kind <= kind;
      item_r.p    <= in_power;
      item_r.e    <= spec_eff;
    end
  end

endmodule
`default_nettype wire

@@ sv/bdlsp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlsp_fifo
// short show-ahead queue between classification and the arithmetic pipeline
// ----------------------------------------------------------------------------
module bdlsp_fifo import bdlsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  item_t      din,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output item_t      dout
);

  localparam int AW = $clog2(QDEPTH);

  item_t               mem_r [QDEPTH];
  logic [AW-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]         cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

@@ sv/bdlsp_loss.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlsp_loss
// twelve stage pipeline: exponentials, loss fraction, belt motor power and
// operand setup for the shared divider
// ----------------------------------------------------------------------------
module bdlsp_loss import bdlsp_pkg::*; #(
  parameter int POWER_FRAC_BITS = 8,
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_valid,
  input  item_t     in_item,
  output logic      out_valid,
  output div_in_t   out_div,
  output side_t     out_side
);

  localparam int F   = POWER_FRAC_BITS;
  localparam int IW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW  = 36 + IW;
  localparam int LAT = 12;
  localparam longint unsigned STEP = (64'd16 << 30) / EXP_TABLE_DEPTH;
  localparam longint unsigned BASE = exp_base(STEP);

  logic [30:0] exp_tab [EXP_TABLE_DEPTH + 1];

  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_tab
    assign exp_tab[g] = exp_entry(g, BASE);
  end

  logic [LAT:1]   v_r;
  item_t          it_r [1:LAT-1];

  logic [55:0]    pa1_r, pa2_r;
  logic           ov1_r, ov2_r;
  logic [PW-1:0]  pp1_r, pp2_r;
  logic [30:0]    t0a_r, t1a_r, t0b_r, t1b_r;
  logic [15:0]    fa_r, fb_r;
  logic [46:0]    da_r, db_r;
  logic [30:0]    t0a4_r, t0b4_r;
  logic [30:0]    ea_r, eb_r;
  logic [53:0]    ca_r;
  logic [56:0]    cb_r;
  logic [26:0]    loss_r, loss8_r, loss9_r, ls_r;
  logic [29:0]    x_r;
  logic [60:0]    qm_r;
  logic [50:0]    pl_r;
  logic [30:0]    d_r;
  div_in_t        div_r;
  side_t          side_r;

  logic [IW-1:0]  idx_a, idx_b;
  logic [51:0]    rnd;
  logic [24:0]    bm;
  logic [46:0]    nb;
  logic [40:0]    ns, es;
  div_in_t        div_nxt;
  side_t          side_nxt;

  assign idx_a = pp1_r[PW-1:36];
  assign idx_b = pp2_r[PW-1:36];

  // final stage: belt power, divider operands
  always_comb begin
    rnd = 52'(pl_r) + 52'(64'd1 << 29);
    bm  = {1'b0, it_r[11].p} + 25'(rnd >> 30);
    nb  = (47'd1 << 46) + 47'(d_r >> 1);
    ns  = {1'b0, it_r[11].p, 16'd0} + 41'(it_r[11].e >> 1);
    es  = {it_r[11].e, 24'd0};

    side_nxt.kind  = it_r[11].kind;
    side_nxt.e     = it_r[11].e;
    side_nxt.zero  = (it_r[11].e == '0);
    side_nxt.motor = it_r[11].p;
    side_nxt.sat   = 1'b0;
    div_nxt.nh     = '0;
    div_nxt.nl     = '0;
    div_nxt.den    = 31'd1;
    case (it_r[11].kind)
      KIND_DIRECT: begin
      end
      KIND_SPEC: begin
        side_nxt.sat = (ns >= es);
        if (!side_nxt.sat && !side_nxt.zero) begin
          div_nxt.nh  = 32'(ns >> 24);
          div_nxt.nl  = ns[23:0];
          div_nxt.den = 31'(it_r[11].e);
        end
      end
      default: begin
        side_nxt.sat   = bm[24];
        side_nxt.motor = bm[24] ? POWER_MAX : bm[23:0];
        div_nxt.nh     = 32'(nb >> 24);
        div_nxt.nl     = nb[23:0];
        div_nxt.den    = d_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-1:1], in_valid};
    end
    if (en) begin
      it_r[1] <= in_item;
      for (int k = 2; k < LAT; k++) begin
        it_r[k] <= it_r[k-1];
      end
      // exponent arguments
      pa1_r <= 56'(K1_Q32) * 56'(in_item.p);
      pa2_r <= 56'(K2_Q32) * 56'(in_item.p);
      // table position
      ov1_r <= (pa1_r[55:F+36] != '0);
      ov2_r <= (pa2_r[55:F+36] != '0);
      pp1_r <= PW'(pa1_r[F+35:F]) * PW'(EXP_TABLE_DEPTH);
      pp2_r <= PW'(pa2_r[F+35:F]) * PW'(EXP_TABLE_DEPTH);
      // lookup, zero beyond the table range
      t0a_r <= ov1_r ? '0 : exp_tab[idx_a];
      t1a_r <= ov1_r ? '0 : exp_tab[idx_a + 1'b1];
      fa_r  <= ov1_r ? '0 : pp1_r[35:20];
      t0b_r <= ov2_r ? '0 : exp_tab[idx_b];
      t1b_r <= ov2_r ? '0 : exp_tab[idx_b + 1'b1];
      fb_r  <= ov2_r ? '0 : pp2_r[35:20];
      // interpolation
      da_r   <= 47'(t0a_r - t1a_r) * 47'(fa_r);
      db_r   <= 47'(t0b_r - t1b_r) * 47'(fb_r);
      t0a4_r <= t0a_r;
      t0b4_r <= t0b_r;
      ea_r   <= t0a4_r - 31'(da_r >> 16);
      eb_r   <= t0b4_r - 31'(db_r >> 16);
      // loss terms
      ca_r   <= 54'(C1_Q30) * 54'(ea_r);
      cb_r   <= 57'(C2_Q30) * 57'(eb_r);
      loss_r <= 27'(ca_r >> 30) + 27'(cb_r >> 30) + C3_Q30;
      // notched 5/7, synchronous 2/7
      x_r     <= (it_r[7].kind == KIND_NOTCH) ? 30'(loss_r) * 30'd5 : 30'(loss_r) << 1;
      loss8_r <= loss_r;
      qm_r    <= 61'(x_r) * 61'(RECIP7);
      loss9_r <= loss8_r;
      ls_r    <= (it_r[9].kind == KIND_NOTCH || it_r[9].kind == KIND_SYNC) ?
                 27'(qm_r >> 33) : loss9_r;
      pl_r    <= 51'(it_r[10].p) * 51'(ls_r);
      d_r     <= ONE_Q30 + 31'(ls_r);
      div_r   <= div_nxt;
      side_r  <= side_nxt;
    end
  end

  assign out_valid = v_r[LAT];
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

@@ sv/bdlsp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlsp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bdlsp_div import bdlsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  div_in_t    in_div,
  input  side_t      in_side,
  output logic       out_valid,
  output logic [23:0] out_q,
  output side_t      out_side
);

  localparam int N = DIV_STAGES;

  logic [N-1:0]  v_r;
  logic [31:0]   rem_r [N];
  logic [23:0]   q_r   [N];
  logic [23:0]   nl_r  [N];
  logic [30:0]   den_r [N];
  side_t         sd_r  [N];

  logic [31:0]   rem_c [N];
  logic [23:0]   q_c   [N];
  logic [23:0]   nl_c  [N];

  always_comb begin
    logic [31:0] rin;
    logic [23:0] qin, nin;
    logic [30:0] din;
    logic [31:0] trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rin = in_div.nh;
        qin = '0;
        nin = in_div.nl;
        din = in_div.den;
      end else begin
        rin = rem_r[k-1];
        qin = q_r[k-1];
        nin = nl_r[k-1];
        din = den_r[k-1];
      end
      trial   = {rin[30:0], nin[23]};
      nl_c[k] = {nin[22:0], 1'b0};
      if (trial >= {1'b0, din}) begin
        rem_c[k] = trial - {1'b0, din};
        q_c[k]   = {qin[22:0], 1'b1};
      end else begin
        rem_c[k] = trial;
        q_c[k]   = {qin[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_c[k];
        q_r[k]   <= q_c[k];
        nl_r[k]  <= nl_c[k];
      end
      den_r[0] <= in_div.den;
      sd_r[0]  <= in_side;
      for (int k = 1; k < N; k++) begin
        den_r[k] <= den_r[k-1];
        sd_r[k]  <= sd_r[k-1];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_q     = q_r[N-1];
  assign out_side  = sd_r[N-1];

endmodule
`default_nettype wire

@@ sv/belt_drive_loss_shaft_power.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// belt_drive_loss_shaft_power
// motor shaft power and drive efficiency behind a belt or direct drive
// ----------------------------------------------------------------------------
// Accepts one transfer per clock unless the output stalls, and returns one
// result for each, in order, through the front register, queue, 12 arithmetic
// stages, 24 divider stages and output register; the divider is a fully
// pipelined one-bit-per-stage unit shared by the specified-drive power and
// the belt efficiency, so throughput stays at one item per cycle unless
// stalled. The back end advances as a whole whenever the output register is
// empty or being taken; a two-entry queue lets the input side keep taking
// transfers across a stall. The user writes specified_efficiency through
// cfg_we/cfg_wdata while the block is idle; the block does not enforce this.
module belt_drive_loss_shaft_power import bdlsp_pkg::*; #(
  parameter int POWER_FRAC_BITS = 8,
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [23:0] load_power
  input  wire logic [2:0]  in_tuser,   // [2:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [23:0] motor_power, [40:24] drive_efficiency
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata   // specified_efficiency
);

  logic [16:0] spec_eff_r;

  logic        push, q_full, q_empty, pop;
  item_t       f_item, q_item;
  logic        adv;

  logic        l_valid;
  div_in_t     l_div;
  side_t       l_side;

  logic        d_valid;
  logic [23:0] d_q;
  side_t       d_side;

  logic        out_valid_r;
  logic [23:0] motor_r, motor_nxt;
  logic [16:0] eff_r, eff_nxt;
  logic [1:0]  status_r, status_nxt;

  // whole back end moves when the output slot frees up
  assign adv = !out_valid_r || out_tready;
  assign pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_eff_r <= EFF_ONE;
    end else if (cfg_we) begin
      spec_eff_r <= cfg_wdata;
    end
  end

  bdlsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_power (in_tdata),
    .spec_eff (spec_eff_r),
    .push     (push),
    .q_full   (q_full),
    .item     (f_item)
  );

  bdlsp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_item),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .dout  (q_item)
  );

  bdlsp_loss #(
    .POWER_FRAC_BITS (POWER_FRAC_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_loss (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (!q_empty),
    .in_item   (q_item),
    .out_valid (l_valid),
    .out_div   (l_div),
    .out_side  (l_side)
  );

  bdlsp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (l_valid),
    .in_div    (l_div),
    .in_side   (l_side),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_side  (d_side)
  );

  // result assembly per drive kind
  always_comb begin
    motor_nxt  = d_side.motor;
    eff_nxt    = EFF_ONE;
    status_nxt = ST_OK;
    case (d_side.kind)
      KIND_DIRECT: begin
      end
      KIND_SPEC: begin
        eff_nxt = d_side.e;
        if (d_side.zero) begin
          // no finite power behind a zero efficiency
          motor_nxt  = POWER_MAX;
          status_nxt = ST_ZERO;
        end else if (d_side.sat) begin
          motor_nxt  = POWER_MAX;
          status_nxt = ST_SAT;
        end else begin
          motor_nxt = d_q;
        end
      end
      default: begin
        eff_nxt    = d_q[16:0];
        status_nxt = d_side.sat ? ST_SAT : ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
    if (adv) begin
      motor_r  <= motor_nxt;
      eff_r    <= eff_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, eff_r, motor_r};
  assign out_tuser  = status_r;

endmodule
`default_nettype wire

@@ sv/bdlsp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdlsp_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module bdlsp_checker import bdlsp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_SAT || out_tuser == ST_ZERO))
    else $error("bad status code");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SAT |-> out_tdata[23:0] == POWER_MAX)
    else $error("saturated status without full scale power");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_ZERO |->
      out_tdata[23:0] == POWER_MAX && out_tdata[40:24] == '0)
    else $error("zero efficiency result malformed");

endmodule

bind belt_drive_loss_shaft_power bdlsp_checker u_bdlsp_checker (.*);
`default_nettype wire
